// ----- hdl/mwo_pkg.sv -----
// Package for the multi-waveform phase oscillator.
// Holds wave codes, field widths, queue status type and the quarter-sine builder.
// No dependencies.
package mwo_pkg;

	localparam int STEP_W   = 31;
	localparam int WAVE_W   = 2;
	localparam int AMP_W    = 15;
	localparam int SAMPLE_W = 16;
	localparam int TBL_W    = 15;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef enum logic [WAVE_W-1:0] {
		WAVE_SINE   = 2'd0,
		WAVE_SQUARE = 2'd1,
		WAVE_SAW    = 2'd2,
		WAVE_SILENT = 2'd3
	} wave_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// Q0.15 quarter-wave entry, integer Taylor series in Q30
	function automatic logic [TBL_W-1:0] quarter_sine(input int unsigned i,
		input int unsigned tbits);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] v;
		logic signed [63:0] sum;
		x    = (HALF_PI_Q30 * 64'(i)) >> tbits;
		x2   = (x * x) >> 30;
		term = x;
		sum  = 64'sd0;
		for (int k = 0; k < 10; k++) begin
			if ((k % 2) == 0) begin
				sum = sum + $signed(term);
			end else begin
				sum = sum - $signed(term);
			end
			term = ((term * x2) >> 30) / 64'((2 * k + 2) * (2 * k + 3));
		end
		if (sum < 0) begin
			sum = 64'sd0;
		end
		v = ($unsigned(sum) + 64'd16384) >> 15;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		return v[TBL_W-1:0];
	endfunction

endpackage

// ----- hdl/mwo_sine_rom.sv -----
// Quarter-wave sine ROM with registered read.
// Contents are built at elaboration from mwo_pkg::quarter_sine.
module mwo_sine_rom #(
	parameter int SINE_TABLE_BITS = 10
) (
	input  logic                           clk,
	input  logic                           en,
	input  logic [SINE_TABLE_BITS:0]       addr,
	output logic [mwo_pkg::TBL_W-1:0]      data
);

	localparam int DEPTH = (1 << SINE_TABLE_BITS) + 1;

	logic [mwo_pkg::TBL_W-1:0] rom [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_rom
		assign rom[i] = mwo_pkg::quarter_sine($unsigned(i), $unsigned(SINE_TABLE_BITS));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data <= rom[addr];
		end
	end

endmodule

// ----- hdl/mwo_queue.sv -----
// Two-entry transaction queue between the front and back of the oscillator.
// Depends on mwo_pkg for the status type.
module mwo_queue #(
	parameter int WIDTH = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [WIDTH-1:0]    wr_data,
	input  logic                pop,
	output logic [WIDTH-1:0]    rd_data,
	output mwo_pkg::q_status_t  status
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	assign rd_data      = mem_q[rd_ptr_q];
	assign status.full  = (count_q == 2'd2);
	assign status.empty = (count_q == 2'd0);

endmodule

// ----- hdl/mwo_front.sv -----
// Front of the oscillator: accepts transactions, holds the phase accumulator
// and classifies each transaction into table address, sign and saw distance.
// Depends on mwo_pkg.
module mwo_front #(
	parameter int PHASE_BITS      = 32,
	parameter int SINE_TABLE_BITS = 10,
	parameter int ENTRY_W         = 2 + 15 + 1 + 11 + 33
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             step_valid,
	output logic                             step_stall,
	input  logic [mwo_pkg::STEP_W-1:0]       phase_step,
	input  logic [mwo_pkg::WAVE_W-1:0]       wave_select,
	input  logic [mwo_pkg::AMP_W-1:0]        amplitude,
	input  mwo_pkg::q_status_t               q_status,
	output logic                             push,
	output logic [ENTRY_W-1:0]               entry
);

	localparam int D_W = PHASE_BITS + 1;
	localparam int A_W = SINE_TABLE_BITS + 1;

	typedef struct packed {
		mwo_pkg::wave_t                 wave;
		logic [mwo_pkg::AMP_W-1:0]      amp;
		logic                           neg;
		logic [A_W-1:0]                 tbl_addr;
		logic [D_W-1:0]                 saw_dist;
	} entry_t;

	logic [PHASE_BITS-1:0]      phase_q;
	logic [1:0]                 quad;
	logic [SINE_TABLE_BITS-1:0] idx;
	logic [PHASE_BITS-1:0]      twice;
	logic                       saw_neg;
	entry_t                     ent;

	assign step_stall = q_status.full;
	assign push       = step_valid && !q_status.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (push) begin
			phase_q <= phase_q + PHASE_BITS'(phase_step);
		end
	end

	assign quad    = phase_q[PHASE_BITS-1 -: 2];
	assign idx     = phase_q[PHASE_BITS-3 -: SINE_TABLE_BITS];
	assign twice   = {phase_q[PHASE_BITS-2:0], 1'b0};
	assign saw_neg = !phase_q[PHASE_BITS-1];

	always_comb begin
		ent.wave = mwo_pkg::wave_t'(wave_select);
		ent.amp  = amplitude;
		if (quad[0]) begin
			ent.tbl_addr = A_W'(1 << SINE_TABLE_BITS) - {1'b0, idx};
		end else begin
			ent.tbl_addr = {1'b0, idx};
		end
		if (saw_neg) begin
			ent.saw_dist = (D_W'(1) << PHASE_BITS) - {1'b0, twice};
		end else begin
			ent.saw_dist = {1'b0, twice};
		end
		case (mwo_pkg::wave_t'(wave_select))
			mwo_pkg::WAVE_SINE: begin
				ent.neg = quad[1];
			end
			mwo_pkg::WAVE_SQUARE: begin
				ent.neg = phase_q[PHASE_BITS-1];
			end
			mwo_pkg::WAVE_SAW: begin
				ent.neg = saw_neg;
			end
			default: begin
				ent.neg = 1'b0;
			end
		endcase
	end

	assign entry = ent;

endmodule

// ----- hdl/mwo_back.sv -----
// Back of the oscillator: table read, products, scaling, sign and output register.
// Depends on mwo_pkg and mwo_sine_rom.
module mwo_back #(
	parameter int PHASE_BITS      = 32,
	parameter int SINE_TABLE_BITS = 10,
	parameter int ENTRY_W         = 2 + 15 + 1 + 11 + 33
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  mwo_pkg::q_status_t                 q_status,
	input  logic [ENTRY_W-1:0]                 entry,
	output logic                               pop,
	output logic                               sample_valid,
	input  logic                               sample_stall,
	output logic signed [mwo_pkg::SAMPLE_W-1:0] sample
);

	localparam int D_W  = PHASE_BITS + 1;
	localparam int A_W  = SINE_TABLE_BITS + 1;
	localparam int LO_W = D_W / 2;
	localparam int HI_W = D_W - LO_W;
	localparam int AW   = mwo_pkg::AMP_W;
	localparam int SP_W = mwo_pkg::TBL_W + AW;
	localparam int PL_W = AW + LO_W;
	localparam int PH_W = AW + HI_W;
	localparam int PS_W = AW + D_W;

	typedef struct packed {
		mwo_pkg::wave_t                 wave;
		logic [mwo_pkg::AMP_W-1:0]      amp;
		logic                           neg;
		logic [A_W-1:0]                 tbl_addr;
		logic [D_W-1:0]                 saw_dist;
	} entry_t;

	entry_t                        ent;
	logic                          en;
	logic [mwo_pkg::TBL_W-1:0]     rom_data;

	logic                          valid_s1;
	mwo_pkg::wave_t                wave_s1;
	logic [AW-1:0]                 amp_s1;
	logic                          neg_s1;
	logic [D_W-1:0]                saw_dist_s1;

	logic                          valid_s2;
	mwo_pkg::wave_t                wave_s2;
	logic [AW-1:0]                 amp_s2;
	logic                          neg_s2;
	logic [SP_W-1:0]               sprod_s2;
	logic [PL_W-1:0]               plo_s2;
	logic [PH_W-1:0]               phi_s2;

	logic                          valid_q;
	logic [mwo_pkg::SAMPLE_W-1:0]  sample_q;

	logic [PS_W-1:0]               saw_sum;
	logic [AW-1:0]                 mag;
	logic [mwo_pkg::SAMPLE_W-1:0]  sample_d;

	assign ent = entry_t'(entry);
	assign en  = !valid_q || !sample_stall;
	assign pop = en && !q_status.empty;

	mwo_sine_rom #(
		.SINE_TABLE_BITS(SINE_TABLE_BITS)
	) u_rom (
		.clk  (clk),
		.en   (en),
		.addr (ent.tbl_addr),
		.data (rom_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_q  <= 1'b0;
		end else if (en) begin
			valid_s1 <= pop;
			valid_s2 <= valid_s1;
			valid_q  <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wave_s1     <= ent.wave;
			amp_s1      <= ent.amp;
			neg_s1      <= ent.neg;
			saw_dist_s1 <= ent.saw_dist;
			wave_s2     <= wave_s1;
			amp_s2      <= amp_s1;
			neg_s2      <= neg_s1;
			sprod_s2    <= SP_W'(rom_data) * SP_W'(amp_s1);
			plo_s2      <= PL_W'(amp_s1) * PL_W'(saw_dist_s1[LO_W-1:0]);
			phi_s2      <= PH_W'(amp_s1) * PH_W'(saw_dist_s1[D_W-1:LO_W]);
			sample_q    <= sample_d;
		end
	end

	assign saw_sum = (PS_W'(phi_s2) << LO_W) + PS_W'(plo_s2);

	always_comb begin
		case (wave_s2)
			mwo_pkg::WAVE_SINE: begin
				mag = sprod_s2[SP_W-1 -: AW];
			end
			mwo_pkg::WAVE_SQUARE: begin
				mag = amp_s2;
			end
			mwo_pkg::WAVE_SAW: begin
				mag = saw_sum[PHASE_BITS +: AW];
			end
			default: begin
				mag = '0;
			end
		endcase
		if (neg_s2) begin
			sample_d = mwo_pkg::SAMPLE_W'(0) - {1'b0, mag};
		end else begin
			sample_d = {1'b0, mag};
		end
	end

	assign sample_valid = valid_q;
	assign sample       = $signed(sample_q);

endmodule

// ----- hdl/multi_waveform_phase_oscillator_top.sv -----
// Multi-waveform phase oscillator (sine, square, saw), top level.
// Depends on mwo_pkg, mwo_front, mwo_queue, mwo_back, mwo_sine_rom.
//
// Input channel (step_valid/step_stall): one transaction per sample tick,
// carrying phase_step, wave_select and amplitude. The sample is formed from
// the phase held before the transaction, then the phase advances by phase_step.
// Output channel (sample_valid/sample_stall): one signed sample per input
// transaction, in order.
// Path: an accepted transaction passes through the queue, the table read,
// the product stage and the output register before its sample appears.
// Throughput: one transaction per cycle while the queue is not full, set by the
// phase add and the pipelined table read and products.
// Reset clears the phase accumulator to zero and empties the queue and pipe.
// When the receiver stalls, the output register and back pipe hold; the
// two-entry queue keeps absorbing transactions until full, then step_stall
// rises.
module multi_waveform_phase_oscillator_top #(
	parameter int PHASE_BITS      = 32,
	parameter int SINE_TABLE_BITS = 10
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                step_valid,
	output logic                                step_stall,
	input  logic [mwo_pkg::STEP_W-1:0]          phase_step,
	input  logic [mwo_pkg::WAVE_W-1:0]          wave_select,
	input  logic [mwo_pkg::AMP_W-1:0]           amplitude,
	output logic                                sample_valid,
	input  logic                                sample_stall,
	output logic signed [mwo_pkg::SAMPLE_W-1:0] sample
);

	localparam int ENTRY_W = mwo_pkg::WAVE_W + mwo_pkg::AMP_W + 1
		+ (SINE_TABLE_BITS + 1) + (PHASE_BITS + 1);

	logic               push;
	logic               pop;
	logic [ENTRY_W-1:0] wr_entry;
	logic [ENTRY_W-1:0] rd_entry;
	mwo_pkg::q_status_t q_status;

	mwo_front #(
		.PHASE_BITS      (PHASE_BITS),
		.SINE_TABLE_BITS (SINE_TABLE_BITS),
		.ENTRY_W         (ENTRY_W)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.step_valid  (step_valid),
		.step_stall  (step_stall),
		.phase_step  (phase_step),
		.wave_select (wave_select),
		.amplitude   (amplitude),
		.q_status    (q_status),
		.push        (push),
		.entry       (wr_entry)
	);

	mwo_queue #(
		.WIDTH (ENTRY_W)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (wr_entry),
		.pop     (pop),
		.rd_data (rd_entry),
		.status  (q_status)
	);

	mwo_back #(
		.PHASE_BITS      (PHASE_BITS),
		.SINE_TABLE_BITS (SINE_TABLE_BITS),
		.ENTRY_W         (ENTRY_W)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_status     (q_status),
		.entry        (rd_entry),
		.pop          (pop),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_status.full))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && q_status.empty))
		else $error("queue read while empty");

	a_sample_range: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid |-> (sample != 16'sh8000))
		else $error("sample magnitude out of range");

	a_stall_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_status.full |-> step_stall)
		else $error("transaction accepted into a full queue");

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for multi_waveform_phase_oscillator_top: random bursts on the step
// channel, random stalls on the sample channel, samples checked against a local predictor.
// Depends on mwo_pkg and the oscillator RTL.
module testbench;

	localparam int PHASE_W        = 32;
	localparam int SINE_BITS      = 10;
	localparam int SINE_SIZE      = 1 << SINE_BITS;
	localparam int RANDOM_ITEMS   = 1450;
	localparam int DRAIN_POINT    = 700;
	localparam int LONG_HOLD_AT   = 300;
	localparam int LONG_HOLD_LEN  = 120;
	localparam int TAIL_CYCLES    = 10;
	localparam int CYCLE_LIMIT    = 200000;

	typedef struct {
		logic [mwo_pkg::STEP_W-1:0] step;
		mwo_pkg::wave_t             wave;
		logic [mwo_pkg::AMP_W-1:0]  amp;
		bit                         drain_first;
	} stim_item_t;

	typedef enum int {
		SINK_FREE,
		SINK_LIGHT,
		SINK_HEAVY,
		SINK_TOGGLE
	} sink_mode_t;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                step_valid = 1'b0;
	logic                                step_stall;
	logic [mwo_pkg::STEP_W-1:0]          phase_step = '0;
	logic [mwo_pkg::WAVE_W-1:0]          wave_select = '0;
	logic [mwo_pkg::AMP_W-1:0]           amplitude = '0;
	logic                                sample_valid;
	logic                                sample_stall = 1'b0;
	logic signed [mwo_pkg::SAMPLE_W-1:0] sample;

	logic [mwo_pkg::TBL_W-1:0]           sine_q15 [0:SINE_SIZE];
	stim_item_t                          pending_items [$];
	logic signed [mwo_pkg::SAMPLE_W-1:0] expected_samples [$];
	logic [PHASE_W-1:0]                  osc_phase = '0;
	logic                                step_taken = 1'b0;
	int unsigned                         samples_checked = 0;
	int unsigned                         error_count = 0;
	int unsigned                         cycle_count = 0;
	int unsigned                         burst_left = 0;
	int unsigned                         gap_left = 0;
	int unsigned                         hold_left = 0;
	int unsigned                         mode_left = 0;
	bit                                  long_hold_done = 1'b0;
	sink_mode_t                          sink_mode = SINK_FREE;

	multi_waveform_phase_oscillator_top #(
		.PHASE_BITS(PHASE_W),
		.SINE_TABLE_BITS(SINE_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.step_valid(step_valid),
		.step_stall(step_stall),
		.phase_step(phase_step),
		.wave_select(wave_select),
		.amplitude(amplitude),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [mwo_pkg::TBL_W-1:0] quarter_sine_q15(input int unsigned i);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned v;
		longint          acc;
		x    = (mwo_pkg::HALF_PI_Q30 * 64'(i)) / 64'(SINE_SIZE);
		x2   = (x * x) >> 30;
		term = x;
		acc  = 0;
		for (int k = 0; k < 10; k++) begin
			if (k % 2 == 0) begin
				acc = acc + longint'(term);
			end else begin
				acc = acc - longint'(term);
			end
			term = ((term * x2) >> 30) / 64'((2 * k + 2) * (2 * k + 3));
		end
		if (acc < 0) begin
			acc = 0;
		end
		v = ($unsigned(acc) + 64'd16384) >> 15;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		return v[mwo_pkg::TBL_W-1:0];
	endfunction

	function automatic logic signed [mwo_pkg::SAMPLE_W-1:0] predict_sample(
		input logic [PHASE_W-1:0] ph, input mwo_pkg::wave_t wave,
		input logic [mwo_pkg::AMP_W-1:0] amp);
		logic [1:0]                   quad;
		int unsigned                  tidx;
		longint unsigned              mag;
		longint unsigned              twice;
		longint unsigned              d;
		logic                         neg;
		logic [mwo_pkg::SAMPLE_W-1:0] m16;
		quad = ph[PHASE_W-1 -: 2];
		mag  = 0;
		neg  = 1'b0;
		case (wave)
			mwo_pkg::WAVE_SINE: begin
				tidx = 32'(ph[PHASE_W-3 -: SINE_BITS]);
				if (quad[0]) begin
					tidx = $unsigned(SINE_SIZE) - tidx;
				end
				mag = (64'(sine_q15[tidx]) * 64'(amp)) >> 15;
				neg = quad[1];
			end
			mwo_pkg::WAVE_SQUARE: begin
				mag = 64'(amp);
				neg = ph[PHASE_W-1];
			end
			mwo_pkg::WAVE_SAW: begin
				twice = 64'(ph) << 1;
				neg   = !ph[PHASE_W-1];
				d     = neg ? ((64'd1 << PHASE_W) - twice) : (twice - (64'd1 << PHASE_W));
				mag   = (64'(amp) * d) >> PHASE_W;
			end
			default: begin
				mag = 0;
			end
		endcase
		m16 = mag[mwo_pkg::SAMPLE_W-1:0];
		if (neg) begin
			m16 = -m16;
		end
		return m16;
	endfunction

	task automatic report_error(input string msg);
		$display("%s", msg);
		error_count++;
	endtask

	task automatic add_item(input logic [mwo_pkg::STEP_W-1:0] step, input mwo_pkg::wave_t wave,
		input logic [mwo_pkg::AMP_W-1:0] amp, input bit drain_first);
		stim_item_t it;
		it.step        = step;
		it.wave        = wave;
		it.amp         = amp;
		it.drain_first = drain_first;
		pending_items.push_back(it);
	endtask

	// source: bursts of transactions with random gaps
	always @(negedge clk) begin : source_drive
		stim_item_t next_item;
		bit         offer;
		offer = 1'b0;
		if (!arst_n) begin
			step_valid <= 1'b0;
		end else if (!step_valid || step_taken) begin
			if (gap_left != 0) begin
				gap_left--;
			end else if (pending_items.size() != 0 &&
				!(pending_items[0].drain_first && expected_samples.size() != 0)) begin
				next_item = pending_items.pop_front();
				offer     = 1'b1;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 40);
					gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left--;
				end
			end
			step_valid <= offer;
			if (offer) begin
				phase_step  <= next_item.step;
				wave_select <= next_item.wave;
				amplitude   <= next_item.amp;
			end
		end
	end

	// sink: stall pattern, with one long hold-off
	always @(negedge clk) begin : sink_stall
		if (!arst_n) begin
			sample_stall <= 1'b0;
		end else begin
			if (!long_hold_done && samples_checked >= LONG_HOLD_AT) begin
				hold_left      = LONG_HOLD_LEN;
				long_hold_done = 1'b1;
			end
			if (mode_left == 0) begin
				sink_mode = sink_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(16, 96);
			end
			mode_left--;
			if (hold_left != 0) begin
				hold_left--;
				sample_stall <= 1'b1;
			end else begin
				case (sink_mode)
					SINK_FREE:  sample_stall <= 1'b0;
					SINK_LIGHT: sample_stall <= ($urandom_range(0, 99) < 30);
					SINK_HEAVY: sample_stall <= ($urandom_range(0, 99) < 75);
					default:    sample_stall <= ~sample_stall;
				endcase
			end
		end
	end

	always @(posedge clk) begin : sample_check
		logic signed [mwo_pkg::SAMPLE_W-1:0] want;
		if (!arst_n) begin
			step_taken <= 1'b0;
		end else begin
			cycle_count++;
			if (sample_valid && !sample_stall) begin
				if (expected_samples.size() == 0) begin
					report_error($sformatf("unexpected sample %0d at cycle %0d",
						sample, cycle_count));
				end else begin
					want = expected_samples.pop_front();
					if (sample !== want) begin
						report_error($sformatf("sample %0d: got %0d, expected %0d",
							samples_checked, sample, want));
					end
				end
				samples_checked++;
			end
			step_taken <= step_valid && !step_stall;
			if (step_valid && !step_stall) begin
				expected_samples.push_back(predict_sample(osc_phase,
					mwo_pkg::wave_t'(wave_select), amplitude));
				osc_phase = osc_phase + PHASE_W'(phase_step);
			end
		end
	end

	initial begin : run_sequence
		logic [mwo_pkg::STEP_W-1:0] step;
		logic [mwo_pkg::AMP_W-1:0]  amp;
		for (int i = 0; i <= SINE_SIZE; i++) begin
			sine_q15[i] = quarter_sine_q15(i);
		end

		add_item(31'h4000_0000, mwo_pkg::WAVE_SAW,    15'h7FFF, 1'b0);
		add_item(31'h4000_0000, mwo_pkg::WAVE_SINE,   15'h7FFF, 1'b0);
		add_item(31'h0000_0000, mwo_pkg::WAVE_SQUARE, 15'h7FFF, 1'b0);
		add_item(31'h0000_0000, mwo_pkg::WAVE_SAW,    15'h7FFF, 1'b0);
		add_item(31'h4000_0000, mwo_pkg::WAVE_SINE,   15'h7FFF, 1'b0);
		add_item(31'h7FFF_FFFF, mwo_pkg::WAVE_SINE,   15'h7FFF, 1'b0);
		add_item(31'h7FFF_FFFF, mwo_pkg::WAVE_SQUARE, 15'h0000, 1'b0);
		add_item(31'h7FFF_FFFF, mwo_pkg::WAVE_SILENT, 15'h7FFF, 1'b0);
		add_item(31'h2AAA_AAAA, mwo_pkg::WAVE_SINE,   15'h0001, 1'b0);
		add_item(31'h5555_5555, mwo_pkg::WAVE_SAW,    15'h0000, 1'b0);
		add_item(31'h0000_0000, mwo_pkg::WAVE_SILENT, 15'h0000, 1'b0);
		add_item(31'h2AAA_AAAA, mwo_pkg::WAVE_SINE,   15'h5555, 1'b0);
		add_item(31'h5555_5555, mwo_pkg::WAVE_SQUARE, 15'h2AAA, 1'b0);
		add_item(31'h0010_0000, mwo_pkg::WAVE_SINE,   15'h7FFF, 1'b0);
		add_item(31'h7FFF_FFFF, mwo_pkg::WAVE_SAW,    15'h7FFF, 1'b0);
		add_item(31'h0123_4567, mwo_pkg::WAVE_SQUARE, 15'h0001, 1'b0);
		add_item(31'h7654_3210, mwo_pkg::WAVE_SINE,   15'h4000, 1'b0);
		add_item(31'h0000_0001, mwo_pkg::WAVE_SAW,    15'h1234, 1'b0);
		add_item(31'h4000_0000, mwo_pkg::WAVE_SINE,   15'h0000, 1'b0);
		add_item(31'h3FFF_FFFF, mwo_pkg::WAVE_SILENT, 15'h7FFF, 1'b0);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			case ($urandom_range(0, 5))
				0:       step = '0;
				1:       step = '1;
				2:       step = mwo_pkg::STEP_W'($urandom_range(1, 1 << 22));
				default: step = mwo_pkg::STEP_W'($urandom);
			endcase
			case ($urandom_range(0, 5))
				0:       amp = '0;
				1:       amp = '1;
				2:       amp = mwo_pkg::AMP_W'($urandom_range(1, 15));
				default: amp = mwo_pkg::AMP_W'($urandom);
			endcase
			add_item(step, mwo_pkg::wave_t'($urandom_range(0, 3)), amp,
				n == 0 || n == DRAIN_POINT);
		end

		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while ((pending_items.size() != 0 || step_valid || expected_samples.size() != 0) &&
			cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
		end else if (error_count == 0 && expected_samples.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ----- files.f -----
hdl/mwo_pkg.sv
hdl/mwo_sine_rom.sv
hdl/mwo_queue.sv
hdl/mwo_front.sv
hdl/mwo_back.sv
hdl/multi_waveform_phase_oscillator_top.sv
bench/testbench.sv
